// ===== rtl/separable_gaussian_blur_rgb_unit_assert.svh =====
// Assertion macros for the separable Gaussian blur unit.
// Used by the top level; needs clk and arst_n in scope at the point of use.
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_UNIT_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBR_ASSERT_IMP(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define GBR_ASSERT_NXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define GBR_ASSERT_IMP(label, a, b, msg)
`define GBR_ASSERT_NXT(label, a, b, msg)
`endif
`endif

// ===== rtl/gbr_pkg.sv =====
// Shared constants, types and helpers for the separable Gaussian blur unit.
// No dependencies.
package gbr_pkg;

	localparam int MAX_RADIUS_DEF = 7;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int ACC_W          = 28;  // 15 taps of 8x16 products
	localparam int WCMP_W         = 13;  // holds widths up to 4096

	typedef enum logic [2:0] {
		REG_WIDTH     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_RADIUS    = 3'd2,
		REG_TAPS_LOW  = 3'd3,
		REG_TAPS_HIGH = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic first;  // load product, drop old sum
		logic acc;    // add product
	} lane_ctrl_t;

	function automatic logic [15:0] tap_sel(input logic [127:0] taps, input logic [2:0] k);
		return taps[k*16 +: 16];
	endfunction

endpackage

// ===== rtl/separable_gaussian_blur_rgb_unit.sv =====
// Separable Gaussian blur of an RGB raster stream.
// Channels: s_axis takes one pixel per transfer (tdata: red, green, blue from
// bit 0 up). m_axis gives blurred pixels with coordinates; tlast marks the
// final result caused by one input pixel. cfg writes width, height, radius
// and the two tap words; write them only while the unit is idle.
// Each pixel runs the horizontal pass over 2r+1 taps, then, for every row
// whose vertical window it completes, the vertical pass over 2r+1 taps. The
// three channels run in three MAC lanes side by side; a merge stage packs
// them into one pixel. One tap per cycle through the lanes: a horizontal
// result passes the issue, drain and latch states, each vertical result the
// issue, drain and emit states, and the horizontal result is then written to
// the row store. A pixel that completes no window runs neither pass. Mid row
// outside the last row, one pixel gives at most one result; row ends and the
// last row give bursts of up to (r+1)^2 results. A single output register
// holds a result; while the receiver stalls, the unit holds that result and
// waits before emitting the next, but it still takes new pixels once the
// current one is finished.
// Reset clears counters, window and configuration to their defaults; the
// row store is not cleared and is only read where it was written this frame.
module separable_gaussian_blur_rgb_unit
	import gbr_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // red_out, green_out, blue_out, column, row, zero pad
	output logic        m_axis_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	`include "separable_gaussian_blur_rgb_unit_assert.svh"

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RING = 2 * MAX_RADIUS;
	localparam int RW   = $clog2(RING);
	localparam int WIN  = 2 * MAX_RADIUS + 1;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_H_ISSUE = 8'b0000_0010,
		ST_H_DRAIN = 8'b0000_0100,
		ST_H_LATCH = 8'b0000_1000,
		ST_V_ISSUE = 8'b0001_0000,
		ST_V_DRAIN = 8'b0010_0000,
		ST_V_EMIT  = 8'b0100_0000,
		ST_WRITE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [10:0]  width_q;
	logic [15:0]  height_q;
	logic [2:0]   radius_q;
	logic [127:0] taps_q;

	// position and windows
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [RW-1:0] rp_q;
	logic [23:0]   win_q [WIN];

	// sequencing
	logic [CW-1:0]      x_q, xhi_q;
	logic [15:0]        y_q, ylo_q, yhi_q;
	logic               yv_q, row_end_q, frame_end_q;
	logic signed [3:0]  d_q;
	logic [23:0]        hval_q;

	// tap stage
	logic [23:0] sample_s1;
	logic [15:0] tap_s1;
	logic        src_mem_s1;
	lane_ctrl_t  ctrl_s1;

	// output register
	logic        out_valid_q;
	logic [23:0] out_pix_q;
	logic [CW-1:0] out_col_q;
	logic [15:0] out_row_q;
	logic        out_last_q;

	// effective configuration
	logic [WCMP_W-1:0] w_lim, w_m1;
	logic [15:0]       h_m1;
	logic [2:0]        r_eff;
	logic signed [3:0] r_s;

	always_comb begin
		if (width_q == '0) begin
			w_lim = WCMP_W'(1);
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			w_lim = WCMP_W'(MAX_WIDTH);
		end else begin
			w_lim = WCMP_W'(width_q);
		end
		w_m1  = w_lim - WCMP_W'(1);
		h_m1  = (height_q == '0) ? 16'd0 : height_q - 16'd1;
		r_eff = (radius_q > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_q;
		r_s   = signed'({1'b0, r_eff});
	end

	logic in_xfer, row_end, last_row, x_run;
	logic [CW-1:0] xlo;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign row_end  = WCMP_W'(col_q) >= w_m1;
	assign last_row = row_q >= h_m1;
	assign x_run    = row_end || (col_q >= CW'(r_eff));
	assign xlo      = (col_q >= CW'(r_eff)) ? col_q - CW'(r_eff) : '0;

	logic [2:0] k_abs;
	assign k_abs = d_q[3] ? 3'(-d_q) : 3'(d_q);

	// horizontal tap position, clamped to the row
	logic signed [CW+1:0] px_sum;
	logic [CW-1:0]        px;
	logic [3:0]           win_idx;
	always_comb begin
		px_sum = signed'({2'b00, x_q}) + (CW+2)'(d_q);
		if (px_sum < 0) begin
			px = '0;
		end else if (px_sum > signed'({2'b00, col_q})) begin
			px = col_q;
		end else begin
			px = px_sum[CW-1:0];
		end
		win_idx = 4'(col_q - px);
	end

	// vertical tap position, clamped to the frame, mapped onto the ring
	logic signed [17:0] py_sum;
	logic [15:0]        py;
	logic               py_cur;
	logic [3:0]         row_gap;
	logic [RW+1:0]      ring_t;
	logic [RW-1:0]      ring_idx;
	always_comb begin
		py_sum = signed'({2'b00, y_q}) + 18'(d_q);
		if (py_sum < 0) begin
			py = '0;
		end else if (py_sum >= signed'({2'b00, row_q})) begin
			py = row_q;
		end else begin
			py = py_sum[15:0];
		end
		py_cur  = (py == row_q);
		row_gap = 4'(row_q - py);
		ring_t = (RW+2)'(rp_q) + (RW+2)'(RING) - (RW+2)'(row_gap);
		ring_idx = (ring_t >= (RW+2)'(RING)) ? RW'(ring_t - (RW+2)'(RING)) : RW'(ring_t);
	end

	// row store
	logic [RW+CW-1:0] mem_raddr;
	logic [23:0]      mem_rdata;
	assign mem_raddr = {ring_idx, x_q};

	gbr_row_store #(.AW(RW + CW)) u_store (
		.clk   (clk),
		.we    (state_q == ST_WRITE),
		.waddr ({rp_q, x_q}),
		.wdata (hval_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// three channel lanes
	logic [23:0] lane_in;
	logic [23:0] lane_out;
	assign lane_in = src_mem_s1 ? mem_rdata : sample_s1;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		gbr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl_s1),
			.sample (lane_in[c*8 +: 8]),
			.tap    (tap_s1),
			.result (lane_out[c*8 +: 8])
		);
	end

	logic emit_ok, last_tap;
	assign emit_ok  = !out_valid_q || m_axis_tready;
	assign last_tap = (d_q == r_s);

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
			radius_q <= 3'd1;
			taps_q   <= '0;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_WIDTH:     width_q  <= cfg_data[10:0];
				REG_HEIGHT:    height_q <= cfg_data[15:0];
				REG_RADIUS:    radius_q <= cfg_data[2:0];
				REG_TAPS_LOW:  taps_q[63:0]   <= cfg_data;
				REG_TAPS_HIGH: taps_q[127:64] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pixel window: shift in on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_xfer) begin
			win_q[0] <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
			for (int i = 1; i < WIN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// tap stage: fetch sample and tap for the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1    <= '0;
			src_mem_s1 <= 1'b0;
		end else begin
			ctrl_s1.first <= (state_q == ST_H_ISSUE || state_q == ST_V_ISSUE) && (d_q == -r_s);
			ctrl_s1.acc   <= (state_q == ST_H_ISSUE || state_q == ST_V_ISSUE);
			src_mem_s1    <= (state_q == ST_V_ISSUE) && !py_cur;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1    <= tap_sel(taps_q, k_abs);
		sample_s1 <= (state_q == ST_V_ISSUE) ? hval_q : win_q[win_idx];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			rp_q        <= '0;
			x_q         <= '0;
			xhi_q       <= '0;
			y_q         <= '0;
			ylo_q       <= '0;
			yhi_q       <= '0;
			yv_q        <= 1'b0;
			row_end_q   <= 1'b0;
			frame_end_q <= 1'b0;
			d_q         <= '0;
			hval_q      <= '0;
			out_valid_q <= 1'b0;
			out_pix_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the held result once taken, unless a new one replaces it
			if (out_valid_q && m_axis_tready && (state_q != ST_V_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						row_end_q   <= row_end;
						frame_end_q <= row_end && last_row;
						x_q         <= xlo;
						xhi_q       <= row_end ? col_q : xlo;
						d_q         <= -r_s;
						if (last_row) begin
							ylo_q <= (row_q >= 16'(r_eff)) ? row_q - 16'(r_eff) : 16'd0;
							yhi_q <= row_q;
							yv_q  <= 1'b1;
						end else begin
							ylo_q <= row_q - 16'(r_eff);
							yhi_q <= row_q - 16'(r_eff);
							yv_q  <= (row_q >= 16'(r_eff));
						end
						if (x_run) begin
							state_q <= ST_H_ISSUE;
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				ST_H_ISSUE: begin
					if (last_tap) begin
						state_q <= ST_H_DRAIN;
					end else begin
						d_q <= d_q + 4'sd1;
					end
				end
				ST_H_DRAIN: begin
					state_q <= ST_H_LATCH;
				end
				ST_H_LATCH: begin
					hval_q <= lane_out;
					y_q    <= ylo_q;
					d_q    <= -r_s;
					state_q <= yv_q ? ST_V_ISSUE : ST_WRITE;
				end
				ST_V_ISSUE: begin
					if (last_tap) begin
						state_q <= ST_V_DRAIN;
					end else begin
						d_q <= d_q + 4'sd1;
					end
				end
				ST_V_DRAIN: begin
					state_q <= ST_V_EMIT;
				end
				ST_V_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						out_pix_q   <= lane_out;
						out_col_q   <= x_q;
						out_row_q   <= y_q;
						out_last_q  <= (x_q == xhi_q) && (y_q == yhi_q);
						d_q         <= -r_s;
						if (y_q == yhi_q) begin
							state_q <= ST_WRITE;
						end else begin
							y_q     <= y_q + 16'd1;
							state_q <= ST_V_ISSUE;
						end
					end
				end
				ST_WRITE: begin
					d_q <= -r_s;
					if (x_q == xhi_q) begin
						state_q <= ST_IDLE;
						if (row_end_q) begin
							col_q <= '0;
							if (frame_end_q) begin
								row_q <= '0;
								rp_q  <= '0;
							end else begin
								row_q <= row_q + 16'd1;
								rp_q  <= (rp_q == RW'(RING - 1)) ? '0 : rp_q + RW'(1);
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
					end else begin
						x_q     <= x_q + CW'(1);
						state_q <= ST_H_ISSUE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// merge stage output: red, green, blue, column, row
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_row_q, 10'(out_col_q),
		out_pix_q[7:0], out_pix_q[15:8], out_pix_q[23:16]};

	`GBR_ASSERT_IMP(a_write_in_run, state_q == ST_WRITE, x_q <= xhi_q, "row store write past run")
	`GBR_ASSERT_IMP(a_emit_row, state_q == ST_V_EMIT, (y_q <= yhi_q) && (yhi_q <= row_q), "emitted row out of window")
	`GBR_ASSERT_NXT(a_hold_emit, (state_q == ST_V_EMIT) && out_valid_q && !m_axis_tready, state_q == ST_V_EMIT, "result emitted over a stalled one")

endmodule

// ===== rtl/gbr_lane.sv =====
// One color channel lane: multiply-accumulate of 8-bit samples by Q0.16 taps,
// truncated and saturated to 8 bits. Depends on gbr_pkg.
module gbr_lane
	import gbr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lane_ctrl_t  ctrl,
	input  logic [7:0]  sample,
	input  logic [15:0] tap,
	output logic [7:0]  result
);

	logic [ACC_W-1:0] acc_q;
	logic [23:0]      prod;
	logic [ACC_W-17:0] whole;

	assign prod = sample * tap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.first) begin
			acc_q <= ACC_W'(prod);
		end else if (ctrl.acc) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

	assign whole  = acc_q[ACC_W-1:16];
	assign result = (whole > (ACC_W-16)'(255)) ? 8'hFF : whole[7:0];

endmodule

// ===== rtl/gbr_row_store.sv =====
// Ring of horizontal results for the last rows: one write and one registered
// read port. No dependencies.
module gbr_row_store #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
